// ===== rtl/core/bdd_pkg.sv =====
`timescale 1ns / 1ps

package bdd_pkg;

  // register field widths
  localparam int RADIUS_W    = 3;
  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;

  // effective radius, enough for any radius limit of the build
  localparam int RAD_EFF_W = 4;
  localparam int RAD_LIMIT = 16;

  // position counters
  localparam int IN_ROW_W   = 13;
  localparam int OUT_ROW_W  = 12;
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_CAP    = 8191;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RADIUS       = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic emit;
    logic last;
  } scan_flags_t;

  // bit rv set when window cell (row slot j, column slot s) lies in the disk of radius rv
  function automatic logic [RAD_LIMIT-1:0] disk_hits(int j, int s);
    logic [RAD_LIMIT-1:0] v;
    int a;
    int b;
    v = '0;
    for (int rv = 0; rv < RAD_LIMIT; rv++) begin
      a = rv - j;
      b = rv - s;
      v[rv] = ((a * a + b * b) <= (rv * rv));
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/bdd_line_store.sv =====
`timescale 1ns / 1ps

module bdd_line_store #(
  parameter int MAX_RADIUS = 7,
  parameter int MAX_WIDTH  = 1024,
  parameter int STORE_ROWS = 16,
  localparam int COL_W     = $clog2(MAX_WIDTH),
  localparam int ROW_SEL_W = $clog2(STORE_ROWS),
  localparam int WIN       = 2 * MAX_RADIUS + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [COL_W-1:0]     wr_col,
  input  logic [ROW_SEL_W-1:0] wr_row,
  input  logic                 pixel,
  input  logic [COL_W-1:0]     rd_col,
  input  logic [COL_W-1:0]     cur_col,
  input  logic [ROW_SEL_W-1:0] cur_row,
  output logic [WIN-1:0]       column
);

  logic [STORE_ROWS-1:0] mem [MAX_WIDTH];
  logic [STORE_ROWS-1:0] rd_word;
  logic [STORE_ROWS-1:0] patched;

  logic                 byp_valid;
  logic [COL_W-1:0]     byp_col;
  logic [ROW_SEL_W-1:0] byp_row;
  logic                 byp_bit;
  logic                 byp_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_col][wr_row] <= pixel;
    end
    rd_word <= mem[rd_col];
  end

  // last write is not yet in the read word when both hit the same column
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= wr_en;
    end
    byp_col <= wr_col;
    byp_row <= wr_row;
    byp_bit <= pixel;
  end

  assign byp_hit = byp_valid && (byp_col == cur_col);

  for (genvar i = 0; i < STORE_ROWS; i++) begin : g_patch
    assign patched[i] = (byp_hit && (byp_row == ROW_SEL_W'(i))) ? byp_bit : rd_word[i];
  end

  // slot 0 is the incoming pixel, slot j the row j above it
  assign column[0] = pixel;

  for (genvar j = 1; j < WIN; j++) begin : g_tap
    localparam int JM = j % STORE_ROWS;
    logic [ROW_SEL_W:0] sel;
    assign sel = ({1'b0, cur_row} >= (ROW_SEL_W + 1)'(JM)) ?
                 ({1'b0, cur_row} - (ROW_SEL_W + 1)'(JM)) :
                 ({1'b0, cur_row} + (ROW_SEL_W + 1)'(STORE_ROWS - JM));
    assign column[j] = patched[sel[ROW_SEL_W-1:0]];
  end

endmodule

// ===== rtl/core/bdd_scan.sv =====
`timescale 1ns / 1ps

module bdd_scan #(
  parameter int MAX_RADIUS = 7,
  parameter int MAX_WIDTH  = 1024,
  parameter int STORE_ROWS = 16,
  localparam int COL_W     = $clog2(MAX_WIDTH),
  localparam int WW        = COL_W + 1,
  localparam int ROW_SEL_W = $clog2(STORE_ROWS),
  localparam int WIN       = 2 * MAX_RADIUS + 1,
  localparam int CNT_W     = WW + bdd_pkg::RAD_EFF_W + 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [bdd_pkg::RAD_EFF_W-1:0]  radius,
  input  logic [WW-1:0]                  width,
  input  logic [bdd_pkg::HEIGHT_W-1:0]   height,
  output logic                           wr_en,
  output logic [COL_W-1:0]               in_col,
  output logic [COL_W-1:0]               col_next,
  output logic [ROW_SEL_W-1:0]           in_row_mod,
  output bdd_pkg::scan_flags_t           flags,
  output logic [WIN-1:0]                 row_ok,
  output logic [WIN-1:0]                 col_ok
);

  localparam int XW = COL_W + 2;
  localparam int YW = bdd_pkg::HEIGHT_W + 1;

  logic [bdd_pkg::IN_ROW_W-1:0]  in_row;
  logic [CNT_W-1:0]              count;
  logic                          started;
  logic [COL_W-1:0]              out_col;
  logic [bdd_pkg::OUT_ROW_W-1:0] out_row;

  logic [WW-1:0]                 col_inc;
  logic                          col_wrap;
  logic [CNT_W-1:0]              thr;
  logic                          started_now;
  logic [bdd_pkg::HEIGHT_W-1:0]  orow_inc;
  logic [WW-1:0]                 ocol_inc;
  logic                          last;
  logic                          emit;
  logic                          restart;
  logic [XW-1:0]                 x_base;
  logic [YW-1:0]                 y_base;

  assign col_inc  = {1'b0, in_col} + WW'(1);
  assign col_wrap = (col_inc >= width);

  // outputs start once the stream is radius rows and radius pixels ahead
  assign thr         = CNT_W'(radius) * CNT_W'(width) + CNT_W'(radius);
  assign started_now = started || (count >= thr);

  assign orow_inc = bdd_pkg::HEIGHT_W'(out_row) + bdd_pkg::HEIGHT_W'(1);
  assign ocol_inc = {1'b0, out_col} + WW'(1);
  assign last     = (orow_inc >= height) && (ocol_inc >= width);

  assign emit    = accept && started_now;
  assign restart = emit && last;
  assign flags   = '{emit: emit, last: last};

  assign wr_en = accept && (in_row < height) && ({1'b0, in_col} < width);

  always_comb begin
    if (rst) begin
      col_next = '0;
    end else if (accept) begin
      if (restart || col_wrap) begin
        col_next = '0;
      end else begin
        col_next = col_inc[COL_W-1:0];
      end
    end else begin
      col_next = in_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col     <= '0;
      in_row     <= '0;
      in_row_mod <= '0;
      count      <= '0;
      started    <= 1'b0;
      out_col    <= '0;
      out_row    <= '0;
    end else if (accept) begin
      in_col <= col_next;
      if (restart) begin
        in_row     <= '0;
        in_row_mod <= '0;
        count      <= '0;
        started    <= 1'b0;
        out_col    <= '0;
        out_row    <= '0;
      end else begin
        if (col_wrap && (in_row < bdd_pkg::IN_ROW_W'(bdd_pkg::ROW_CAP))) begin
          in_row <= in_row + bdd_pkg::IN_ROW_W'(1);
          if (in_row_mod == ROW_SEL_W'(STORE_ROWS - 1)) begin
            in_row_mod <= '0;
          end else begin
            in_row_mod <= in_row_mod + ROW_SEL_W'(1);
          end
        end
        if (count != '1) begin
          count <= count + CNT_W'(1);
        end
        started <= started_now;
        if (emit) begin
          if (ocol_inc >= width) begin
            out_col <= '0;
            out_row <= out_row + bdd_pkg::OUT_ROW_W'(1);
          end else begin
            out_col <= ocol_inc[COL_W-1:0];
          end
        end
      end
    end
  end

  // frame edges seen from the output pixel, one flag per window slot
  assign x_base = XW'(out_col) + XW'(radius);
  assign y_base = YW'(out_row) + YW'(radius);

  for (genvar s = 0; s < WIN; s++) begin : g_col_ok
    assign col_ok[s] = (x_base >= XW'(s)) && (x_base < (XW'(width) + XW'(s)));
  end

  for (genvar j = 0; j < WIN; j++) begin : g_row_ok
    assign row_ok[j] = (y_base >= YW'(j)) && (y_base < (YW'(height) + YW'(j)));
  end

endmodule

// ===== rtl/core/bdd_window.sv =====
`timescale 1ns / 1ps

module bdd_window #(
  parameter int MAX_RADIUS = 7,
  localparam int WIN       = 2 * MAX_RADIUS + 1
) (
  input  logic                          clk,
  input  logic                          shift,
  input  logic [WIN-1:0]                column,
  input  logic [WIN-1:0]                row_ok,
  input  logic [WIN-1:0]                col_ok,
  input  logic [bdd_pkg::RAD_EFF_W-1:0] radius,
  output logic                          hit
);

  logic [WIN-1:0]       win [WIN];
  logic [WIN-1:0]       row_ok_q;
  logic [WIN-1:0]       col_ok_q;
  logic [WIN*WIN-1:0]   cells;

  // slot 0 holds the newest column
  always_ff @(posedge clk) begin
    if (shift) begin
      win[0] <= column;
      for (int s = 1; s < WIN; s++) begin
        win[s] <= win[s-1];
      end
      row_ok_q <= row_ok;
      col_ok_q <= col_ok;
    end
  end

  for (genvar s = 0; s < WIN; s++) begin : g_col
    for (genvar j = 0; j < WIN; j++) begin : g_row
      localparam logic [bdd_pkg::RAD_LIMIT-1:0] HITS = bdd_pkg::disk_hits(j, s);
      assign cells[s*WIN + j] = win[s][j] & row_ok_q[j] & col_ok_q[s] & HITS[radius];
    end
  end

  assign hit = |cells;

endmodule

// ===== rtl/core/binary_disk_dilation_top.sv =====
`timescale 1ns / 1ps

// channel  | handshake                    | payload
// ---------+------------------------------+-----------------------------------
// in       | in_valid / in_ready          | operation, mask_bit
// out      | out_valid / out_ready        | dilated_bit, frame_last
// cfg      | cfg_write (no wait)          | cfg_index, cfg_data
//
// one item per cycle while the consumer keeps up; a result passes the window stage,
// then the output register, before it leaves
// the line store read is issued ahead, at the next input column,
// with a bypass for the write of the previous cycle
// rst clears counters and handshake state; the line store has no clearing pass
// in_ready drops only while the window stage and the output register both hold
// a result that the consumer has not taken

module binary_disk_dilation_top #(
  parameter int MAX_RADIUS = 7,
  parameter int MAX_WIDTH  = 1024,
  parameter int STORE_ROWS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             operation,
  input  logic                             mask_bit,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             dilated_bit,
  output logic                             frame_last,
  input  logic                             cfg_write,
  input  logic [bdd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bdd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WW        = COL_W + 1;
  localparam int ROW_SEL_W = $clog2(STORE_ROWS);
  localparam int WIN       = 2 * MAX_RADIUS + 1;
  localparam int WIDE_W    = bdd_pkg::WIDTH_W + 2;

  // configuration registers
  logic [bdd_pkg::RADIUS_W-1:0] radius_reg;
  logic [bdd_pkg::WIDTH_W-1:0]  frame_width_reg;
  logic [bdd_pkg::HEIGHT_W-1:0] frame_height_reg;

  // clamped values used by the datapath
  logic [bdd_pkg::RAD_EFF_W-1:0] r_eff;
  logic [WIDE_W-1:0]             width_wide;
  logic [WIDE_W-1:0]             w_eff_wide;
  logic [WW-1:0]                 w_eff;
  logic [bdd_pkg::HEIGHT_W-1:0]  h_eff;

  logic                  accept;
  logic                  pixel;
  logic                  wr_en;
  logic [COL_W-1:0]      in_col;
  logic [COL_W-1:0]      col_next;
  logic [ROW_SEL_W-1:0]  in_row_mod;
  bdd_pkg::scan_flags_t  flags;
  logic [WIN-1:0]        row_ok;
  logic [WIN-1:0]        col_ok;
  logic [WIN-1:0]        column;
  logic                  hit;

  // window stage and output register
  logic s1_valid;
  logic s1_last;
  logic advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_reg       <= '0;
      frame_width_reg  <= bdd_pkg::WIDTH_W'(1024);
      frame_height_reg <= bdd_pkg::HEIGHT_W'(1024);
    end else if (cfg_write) begin
      unique case (cfg_index)
        bdd_pkg::CFG_RADIUS:       radius_reg       <= cfg_data[bdd_pkg::RADIUS_W-1:0];
        bdd_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[bdd_pkg::WIDTH_W-1:0];
        bdd_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[bdd_pkg::HEIGHT_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // out-of-range settings clamp to the supported range
  assign r_eff = ({1'b0, radius_reg} > bdd_pkg::RAD_EFF_W'(MAX_RADIUS)) ?
                 bdd_pkg::RAD_EFF_W'(MAX_RADIUS) : {1'b0, radius_reg};

  assign width_wide = {2'b00, frame_width_reg};

  always_comb begin
    if (frame_width_reg == '0) begin
      w_eff_wide = WIDE_W'(1);
    end else if (width_wide > WIDE_W'(MAX_WIDTH)) begin
      w_eff_wide = WIDE_W'(MAX_WIDTH);
    end else begin
      w_eff_wide = width_wide;
    end
  end

  assign w_eff = w_eff_wide[WW-1:0];

  always_comb begin
    if (frame_height_reg == '0) begin
      h_eff = bdd_pkg::HEIGHT_W'(1);
    end else if (frame_height_reg > bdd_pkg::HEIGHT_W'(bdd_pkg::MAX_HEIGHT)) begin
      h_eff = bdd_pkg::HEIGHT_W'(bdd_pkg::MAX_HEIGHT);
    end else begin
      h_eff = frame_height_reg;
    end
  end

  // handshake: the window stage moves on when the output register is empty or being taken
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  // drain ticks carry a zero pixel
  assign pixel = !operation && mask_bit;

  bdd_scan #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH),
    .STORE_ROWS (STORE_ROWS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .radius     (r_eff),
    .width      (w_eff),
    .height     (h_eff),
    .wr_en      (wr_en),
    .in_col     (in_col),
    .col_next   (col_next),
    .in_row_mod (in_row_mod),
    .flags      (flags),
    .row_ok     (row_ok),
    .col_ok     (col_ok)
  );

  // column of the new pixel and the rows above it
  bdd_line_store #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH),
    .STORE_ROWS (STORE_ROWS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_col  (in_col),
    .wr_row  (in_row_mod),
    .pixel   (pixel),
    .rd_col  (col_next),
    .cur_col (in_col),
    .cur_row (in_row_mod),
    .column  (column)
  );

  // disk window: OR of the masked cells around the output pixel
  bdd_window #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_window (
    .clk    (clk),
    .shift  (accept),
    .column (column),
    .row_ok (row_ok),
    .col_ok (col_ok),
    .radius (r_eff),
    .hit    (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= flags.emit;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_last <= flags.last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      dilated_bit <= hit;
      frame_last  <= s1_last;
    end
  end

`ifndef SYNTH
  // a pending window result is never overwritten by a new item
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |-> !accept)
    else $error("window stage overwritten while holding a result");

  // a window result with a free output register shows up at the output
  a_result_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (!out_valid || out_ready)) |=> out_valid)
    else $error("window result lost on its way to the output register");

  // the block is ready for items right after reset
  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst) |-> in_ready)
    else $error("input not ready after reset");
`endif

endmodule
